// File: sv/pgdd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgdd_pkg
// Shared types and constants of the pheromone grid deposit/decay block.
// ----------------------------------------------------------------------------
package pgdd_pkg;

  localparam int LVL_W     = 16;
  localparam int X_W       = 6;
  localparam int Y_W       = 6;
  localparam int CMD_W     = 2;
  localparam int CH_W      = 2;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_GRID_W = 64;
  localparam int DEF_GRID_H = 64;

  localparam logic [CMD_W-1:0] CMD_DEPOSIT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DECAY   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

  localparam logic [CH_W-1:0] CH_HOME = 2'd0;
  localparam logic [CH_W-1:0] CH_FOOD = 2'd1;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SNAP_THRESHOLD = 2'd2;

  localparam logic [LVL_W-1:0] RST_MAX_LEVEL      = 16'd65535;
  localparam logic [LVL_W-1:0] RST_DECAY_FACTOR   = 16'd64880;
  localparam logic [LVL_W-1:0] RST_SNAP_THRESHOLD = 16'd64;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_SWEEP,
    ST_DRAIN
  } state_t;

  // marks one cell moving through the decay pipeline
  typedef struct packed {
    logic vld;
    logic last;
  } sweep_tag_t;

endpackage

// File: sv/pheromone_grid_deposit_decay_top.sv
`timescale 1ns / 1ps
// deposit, read and unknown commands: result strobe in the cycle after accept, busy until back in idle
// decay tick: one cell per cycle through a 2-stage multiply/snap pipeline, result strobe
//   when the last cell is written back, busy until back in idle
// reset: a clearing pass writes zero to every cell with busy high
// the receiver cannot stall: each result is on out_level for exactly one cycle
// ----------------------------------------------------------------------------
// pheromone_grid_deposit_decay_top
// Home and food trail level maps with saturating deposit and full-grid decay.
// ----------------------------------------------------------------------------
module pheromone_grid_deposit_decay_top #(
  parameter int GRID_W = pgdd_pkg::DEF_GRID_W,
  parameter int GRID_H = pgdd_pkg::DEF_GRID_H
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [pgdd_pkg::CMD_W-1:0]     in_cmd,
  input  logic [pgdd_pkg::X_W-1:0]       in_x,
  input  logic [pgdd_pkg::Y_W-1:0]       in_y,
  input  logic [pgdd_pkg::CH_W-1:0]      in_channel,
  input  logic [pgdd_pkg::LVL_W-1:0]     in_amount,
  output logic                           out_valid,
  output logic [pgdd_pkg::LVL_W-1:0]     out_level,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pgdd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pgdd_pkg::LVL_W-1:0]     cfg_data
);
  import pgdd_pkg::*;

  localparam int NCELLS = GRID_W * GRID_H;
  localparam int ADDR_W = $clog2(NCELLS);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(NCELLS - 1);

  state_t state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              cnt_last;

  logic [LVL_W-1:0] max_level_r, decay_factor_r, snap_threshold_r;

  logic [CMD_W-1:0]  cmd_r;
  logic [CH_W-1:0]   ch_r;
  logic [LVL_W-1:0]  amount_r;
  logic [ADDR_W-1:0] idx_r;
  logic              hit_r;

  logic              accept;
  logic              in_grid;
  logic              in_hit;
  logic [ADDR_W-1:0] in_idx;

  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic              home_we, food_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [LVL_W-1:0]  home_wdata, food_wdata;
  logic [LVL_W-1:0]  home_rdata, food_rdata;

  sweep_tag_t        tag_in;
  sweep_tag_t        dec_tag;
  logic [ADDR_W-1:0] dec_addr;
  logic [LVL_W-1:0]  dec_home, dec_food;

  logic [LVL_W-1:0]  old_level;
  logic [LVL_W:0]    dep_sum;
  logic [LVL_W-1:0]  dep_level;

  // configuration: always ready, writes to unused indexes fall away
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_level_r      <= RST_MAX_LEVEL;
      decay_factor_r   <= RST_DECAY_FACTOR;
      snap_threshold_r <= RST_SNAP_THRESHOLD;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_LEVEL:      max_level_r      <= cfg_data;
        REG_DECAY_FACTOR:   decay_factor_r   <= cfg_data;
        REG_SNAP_THRESHOLD: snap_threshold_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // request decode
  assign accept  = start && !busy;
  assign in_grid = (32'(in_x) < GRID_W) && (32'(in_y) < GRID_H);
  assign in_hit  = in_grid && ((in_channel == CH_HOME) || (in_channel == CH_FOOD));
  assign in_idx  = ADDR_W'(32'(in_y) * GRID_W + 32'(in_x));

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_cmd;
      ch_r     <= in_channel;
      amount_r <= in_amount;
      idx_r    <= in_idx;
      hit_r    <= in_hit;
    end
  end

  // control
  assign cnt_last = cnt_r == LAST_CELL;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (cnt_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_nxt = (in_cmd == CMD_DECAY) ? ST_SWEEP : ST_ACCESS;
      end
      ST_ACCESS: state_nxt = ST_IDLE;
      ST_SWEEP: begin
        if (cnt_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (dec_tag.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // deposit arithmetic on the level read back
  assign old_level = (ch_r == CH_FOOD) ? food_rdata : home_rdata;
  assign dep_sum   = {1'b0, old_level} + {1'b0, amount_r};
  assign dep_level = (dep_sum > {1'b0, max_level_r}) ? max_level_r : dep_sum[LVL_W-1:0];

  always_comb begin
    busy       = 1'b1;
    out_valid  = 1'b0;
    out_level  = '0;
    cnt_nxt    = '0;
    mem_re     = 1'b0;
    mem_raddr  = in_idx;
    tag_in     = '0;
    home_we    = 1'b0;
    food_we    = 1'b0;
    mem_waddr  = dec_addr;
    home_wdata = dec_home;
    food_wdata = dec_food;
    case (state_r)
      ST_CLEAR: begin
        cnt_nxt    = cnt_last ? '0 : cnt_r + 1'b1;
        home_we    = 1'b1;
        food_we    = 1'b1;
        mem_waddr  = cnt_r;
        home_wdata = '0;
        food_wdata = '0;
      end
      ST_IDLE: begin
        busy   = 1'b0;
        mem_re = start;
      end
      ST_ACCESS: begin
        out_valid = 1'b1;
        mem_waddr = idx_r;
        case (cmd_r)
          CMD_DEPOSIT: begin
            if (hit_r) begin
              out_level  = dep_level;
              home_we    = ch_r == CH_HOME;
              food_we    = ch_r == CH_FOOD;
              home_wdata = dep_level;
              food_wdata = dep_level;
            end
          end
          CMD_READ: begin
            if (hit_r) out_level = old_level;
          end
          default: out_level = '0;
        endcase
      end
      ST_SWEEP: begin
        cnt_nxt     = cnt_last ? '0 : cnt_r + 1'b1;
        mem_re      = 1'b1;
        mem_raddr   = cnt_r;
        tag_in.vld  = 1'b1;
        tag_in.last = cnt_last;
        home_we     = dec_tag.vld;
        food_we     = dec_tag.vld;
      end
      ST_DRAIN: begin
        home_we   = dec_tag.vld;
        food_we   = dec_tag.vld;
        out_valid = dec_tag.last;
      end
      default: ;
    endcase
  end

  pgdd_level_mem #(
    .DEPTH  (NCELLS),
    .ADDR_W (ADDR_W)
  ) u_home_mem (
    .clk   (clk),
    .we    (home_we),
    .waddr (mem_waddr),
    .wdata (home_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (home_rdata)
  );

  pgdd_level_mem #(
    .DEPTH  (NCELLS),
    .ADDR_W (ADDR_W)
  ) u_food_mem (
    .clk   (clk),
    .we    (food_we),
    .waddr (mem_waddr),
    .wdata (food_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (food_rdata)
  );

  pgdd_decay_unit #(
    .ADDR_W (ADDR_W)
  ) u_decay (
    .clk            (clk),
    .rst_n          (rst_n),
    .tag_in         (tag_in),
    .addr_in        (cnt_r),
    .home_rd        (home_rdata),
    .food_rd        (food_rdata),
    .decay_factor   (decay_factor_r),
    .snap_threshold (snap_threshold_r),
    .wr_tag         (dec_tag),
    .wr_addr        (dec_addr),
    .home_wr        (dec_home),
    .food_wr        (dec_food)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("request accepted but block not busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_decay_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    dec_tag.vld |-> (state_r == ST_SWEEP || state_r == ST_DRAIN))
    else $error("decay write outside of a sweep");

  a_tick_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && state_r == ST_DRAIN) |-> (out_level == '0))
    else $error("decay tick result not zero");

endmodule

// File: sv/pgdd_level_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgdd_level_mem
// One level map: single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module pgdd_level_mem #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [ADDR_W-1:0]        waddr,
  input  logic [pgdd_pkg::LVL_W-1:0] wdata,
  input  logic                     re,
  input  logic [ADDR_W-1:0]        raddr,
  output logic [pgdd_pkg::LVL_W-1:0] rdata
);
  import pgdd_pkg::*;

  logic [LVL_W-1:0] mem [DEPTH];
  logic [LVL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/pgdd_decay_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgdd_decay_unit
// Two-stage decay pipeline: scale both levels, then snap small cells to zero.
// ----------------------------------------------------------------------------
module pgdd_decay_unit #(
  parameter int ADDR_W = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pgdd_pkg::sweep_tag_t       tag_in,
  input  logic [ADDR_W-1:0]          addr_in,
  input  logic [pgdd_pkg::LVL_W-1:0] home_rd,
  input  logic [pgdd_pkg::LVL_W-1:0] food_rd,
  input  logic [pgdd_pkg::LVL_W-1:0] decay_factor,
  input  logic [pgdd_pkg::LVL_W-1:0] snap_threshold,
  output pgdd_pkg::sweep_tag_t       wr_tag,
  output logic [ADDR_W-1:0]          wr_addr,
  output logic [pgdd_pkg::LVL_W-1:0] home_wr,
  output logic [pgdd_pkg::LVL_W-1:0] food_wr
);
  import pgdd_pkg::*;

  sweep_tag_t        rd_tag_r, mul_tag_r;
  logic [ADDR_W-1:0] rd_addr_r, mul_addr_r;
  logic [LVL_W-1:0]  home_sc_r, food_sc_r;
  logic [2*LVL_W-1:0] prod_home, prod_food;
  logic [LVL_W:0]    sum;
  logic              snap;

  // tag and address follow the read data of the memories
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_tag_r  <= '0;
      mul_tag_r <= '0;
    end else begin
      rd_tag_r  <= tag_in;
      mul_tag_r <= rd_tag_r;
    end
  end

  assign prod_home = {{LVL_W{1'b0}}, home_rd} * {{LVL_W{1'b0}}, decay_factor};
  assign prod_food = {{LVL_W{1'b0}}, food_rd} * {{LVL_W{1'b0}}, decay_factor};

  always_ff @(posedge clk) begin
    rd_addr_r  <= addr_in;
    mul_addr_r <= rd_addr_r;
    home_sc_r  <= prod_home[2*LVL_W-1:LVL_W];
    food_sc_r  <= prod_food[2*LVL_W-1:LVL_W];
  end

  assign sum  = {1'b0, home_sc_r} + {1'b0, food_sc_r};
  assign snap = sum < {1'b0, snap_threshold};

  assign wr_tag  = mul_tag_r;
  assign wr_addr = mul_addr_r;
  assign home_wr = snap ? '0 : home_sc_r;
  assign food_wr = snap ? '0 : food_sc_r;

  a_last_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_tag.last |-> wr_tag.vld)
    else $error("decay write marked last without valid");

  a_pipe_advance: assert property (@(posedge clk) disable iff (!rst_n)
    rd_tag_r.vld |=> mul_tag_r.vld)
    else $error("decay pipeline dropped a cell");

  a_snap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_tag.vld && snap) |-> (home_wr == '0 && food_wr == '0))
    else $error("snapped cell not cleared");

endmodule
